[src/paged_address_translator_macros.svh]
// Assertion macros shared by the paged address translator RTL.
`ifndef PAGED_ADDRESS_TRANSLATOR_MACROS_SVH
`define PAGED_ADDRESS_TRANSLATOR_MACROS_SVH

`ifndef SYNTHESIS

`define PAT_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

`define PAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`else

`define PAT_ASSERT_IMPLIES(name, clk, rst, ante, cons)

`define PAT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[src/pat_pkg.sv]
// Shared types and codes of the paged address translator.
package pat_pkg;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned PID_W    = 6;
   localparam int unsigned PAGE_W   = 5;
   localparam int unsigned COUNT_W  = 6;
   localparam int unsigned FRAME_W  = 6;
   localparam int unsigned OFFSET_W = 6;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned ADDR_W   = 12;
   localparam int unsigned FREE_W   = 13;
   localparam int unsigned SIZE_W   = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned PROD_W   = FRAME_W + SIZE_W;

   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

   localparam logic [OPCODE_W-1:0] OP_ALLOCATE  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_MAP       = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FRAME    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PROC     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PAGE     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OFFSET   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_TOO_MANY = 3'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_BUDGET   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_COUNT = 2'd3;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [PID_W-1:0]    process_id;
      logic [PAGE_W-1:0]   page_number;
      logic [COUNT_W-1:0]  pages_wanted;
      logic [FRAME_W-1:0]  frame_number;
      logic [OFFSET_W-1:0] page_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   physical_address;
      logic [FREE_W-1:0]   free_pages;
   } rsp_type;

   // Outcome of the checks on one request, handed from the checker to the top.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                held_we;
      logic [COUNT_W-1:0]  held_wdata;
      logic                frame_we;
      logic                free_we;
      logic [FREE_W-1:0]   free_wdata;
      logic                xlate_ok;
   } dec_type;

endpackage

[src/pat_check.sv]
// Request checks and state updates decided from the looked-up table entries.
module pat_check #(
   parameter int unsigned MAX_PROCESSES = 64,
   parameter int unsigned MAX_PAGES     = 32,
   parameter int unsigned RAM_FRAMES    = 64
) (
   input  pat_pkg::req_type                   req,
   input  logic [pat_pkg::SIZE_W-1:0]         page_size,
   input  logic [pat_pkg::SIZE_W-1:0]         frame_count,
   input  logic [pat_pkg::SIZE_W-1:0]         process_count,
   input  logic [pat_pkg::FREE_W-1:0]         free_count,
   input  logic [pat_pkg::COUNT_W-1:0]        pages_held,
   output pat_pkg::dec_type                   dec
);
   import pat_pkg::*;

   logic proc_ok;
   logic page_ok;
   logic frame_ok;

   assign proc_ok = ({1'b0, req.process_id} < process_count) &&
                    (32'(req.process_id) < MAX_PROCESSES);
   assign page_ok = ({1'b0, req.page_number} < pages_held) &&
                    (32'(req.page_number) < MAX_PAGES);
   assign frame_ok = ({1'b0, req.frame_number} < frame_count) &&
                     (32'(req.frame_number) < RAM_FRAMES);

   always_comb begin
      dec = '0;
      dec.status = ST_OK;
      dec.free_wdata = free_count - FREE_W'(req.pages_wanted);
      case (req.opcode)
         OP_ALLOCATE: begin
            if (!proc_ok) begin
               dec.status = ST_PROC;
            end else if (32'(req.pages_wanted) > MAX_PAGES) begin
               dec.status = ST_TOO_MANY;
               dec.held_we = 1'b1;
            end else if (FREE_W'(req.pages_wanted) > free_count) begin
               dec.status = ST_FULL;
               dec.held_we = 1'b1;
            end else begin
               dec.held_we = 1'b1;
               dec.held_wdata = req.pages_wanted;
               dec.free_we = 1'b1;
            end
         end
         OP_MAP: begin
            if (!proc_ok) begin
               dec.status = ST_PROC;
            end else if (!page_ok) begin
               dec.status = ST_PAGE;
            end else if (!frame_ok) begin
               dec.status = ST_FRAME;
            end else begin
               dec.frame_we = 1'b1;
            end
         end
         OP_TRANSLATE: begin
            if (!proc_ok) begin
               dec.status = ST_PROC;
            end else if (!page_ok) begin
               dec.status = ST_PAGE;
            end else if ({1'b0, req.page_offset} >= page_size) begin
               dec.status = ST_OFFSET;
            end else begin
               dec.xlate_ok = 1'b1;
            end
         end
         default: begin
            dec.status = ST_OK;
         end
      endcase
   end

endmodule

[src/paged_address_translator.sv]
// Paged address translator top level: page-count and frame tables in memory.
// Requests enter only when idle, pass the lookup state (page-count and frame memory
// read-modify-write, frame times page-size multiply) and the calculation state,
// which holds until the output register can load. Reset is synchronous: control and
// the free-page count clear at once, configuration loads its reset values, page
// counts read as zero through per-process valid bits, no clearing pass.
`include "paged_address_translator_macros.svh"

module paged_address_translator #(
   parameter int unsigned MAX_PROCESSES = 64,
   parameter int unsigned MAX_PAGES     = 32,
   parameter int unsigned RAM_FRAMES    = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pat_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pat_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_we,
   input  logic [pat_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pat_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pat_pkg::*;

   localparam int unsigned PROC_IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int unsigned FT_DEPTH   = MAX_PROCESSES * MAX_PAGES;
   localparam int unsigned FT_ADDR_W  = (FT_DEPTH > 1) ? $clog2(FT_DEPTH) : 1;

   // The sequencer walks each request through lookup and address calculation.
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOOK = 3'b010,
      S_CALC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers. The page budget itself is not kept: writing it
   // only reloads the running free-page count.
   logic [SIZE_W-1:0] page_size_ff;
   logic [SIZE_W-1:0] frame_count_ff;
   logic [SIZE_W-1:0] process_count_ff;
   logic [FREE_W-1:0] free_count_ff;

   // Page-count memory, one entry per process, plus a valid bit per entry so
   // that reset makes every count read as zero without a sweep.
   logic [COUNT_W-1:0]       pages_held_mem [MAX_PROCESSES];
   logic [MAX_PROCESSES-1:0] held_vld_ff;

   // Frame memory, one entry per process page. It is never cleared: a frame
   // is only defined once a map request has written it.
   logic [FRAME_W-1:0] frame_mem [FT_DEPTH];

   // Request held for the duration of its processing, plus the addresses it
   // uses for the lookup and later write-back.
   req_type                req_ff;
   logic [PROC_IDX_W-1:0]  proc_idx_in, proc_idx_ff;
   logic [FT_ADDR_W-1:0]   ft_addr_in, ft_addr_ff;

   // Registered memory read data.
   logic [COUNT_W-1:0] held_rdata_ff;
   logic               held_vld_rd_ff;
   logic [FRAME_W-1:0] frame_rdata_ff;

   // Results of the lookup stage.
   logic [PROD_W-1:0]   prod_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                xlate_ok_ff;

   // Output register, which lets the next request enter while a response waits.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic               req_fire;
   logic               rsp_load;
   logic [COUNT_W-1:0] pages_held_eff;
   dec_type            dec;
   logic               held_we;
   logic               frame_we;
   logic [PROD_W:0]    addr_sum;
   logic [ADDR_W-1:0]  addr_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == S_CALC) && (!rsp_valid_ff || rsp_ready);

   // Table addresses for the incoming request. Out-of-range processes or pages
   // may alias other entries on read, but such requests never write.
   assign proc_idx_in = PROC_IDX_W'(req_payload.process_id);
   assign ft_addr_in  = FT_ADDR_W'(32'(req_payload.process_id) * MAX_PAGES +
                                   32'(req_payload.page_number));

   // A process whose entry was never written since reset holds no pages.
   assign pages_held_eff = held_vld_rd_ff ? held_rdata_ff : '0;

   pat_check #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_PAGES     (MAX_PAGES),
      .RAM_FRAMES    (RAM_FRAMES)
   ) u_check (
      .req           (req_ff),
      .page_size     (page_size_ff),
      .frame_count   (frame_count_ff),
      .process_count (process_count_ff),
      .free_count    (free_count_ff),
      .pages_held    (pages_held_eff),
      .dec           (dec)
   );

   // Memory writes happen only at the end of the lookup cycle. The next request
   // is accepted only after the calculation state returns the sequencer to idle, so no
   // read can overlap a pending write to the same entry.
   assign held_we  = (state_ff == S_LOOK) && dec.held_we;
   assign frame_we = (state_ff == S_LOOK) && dec.frame_we;

   // Address calculation: product plus offset, saturated to the address range.
   assign addr_sum = {1'b0, prod_ff} + (PROD_W + 1)'(req_ff.page_offset);
   assign addr_sat = (addr_sum > (PROD_W + 1)'(ADDR_MAX)) ? ADDR_MAX : ADDR_W'(addr_sum);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration port and the free-page count.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff     <= SIZE_W'(1);
         frame_count_ff   <= SIZE_W'(64);
         process_count_ff <= '0;
         free_count_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PAGE_SIZE:     page_size_ff     <= SIZE_W'(csr_wdata);
               CSR_PAGE_BUDGET:   free_count_ff    <= FREE_W'(csr_wdata);
               CSR_FRAME_COUNT:   frame_count_ff   <= SIZE_W'(csr_wdata);
               CSR_PROCESS_COUNT: process_count_ff <= SIZE_W'(csr_wdata);
               default: begin
               end
            endcase
         end else if ((state_ff == S_LOOK) && dec.free_we) begin
            free_count_ff <= dec.free_wdata;
         end
      end
   end

   // Request capture and table addresses.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff      <= req_payload;
         proc_idx_ff <= proc_idx_in;
         ft_addr_ff  <= ft_addr_in;
      end
   end

   // Page-count memory with registered read.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         held_rdata_ff <= pages_held_mem[proc_idx_in];
      end
      if (held_we) begin
         pages_held_mem[proc_idx_ff] <= dec.held_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff    <= '0;
         held_vld_rd_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            held_vld_rd_ff <= held_vld_ff[proc_idx_in];
         end
         if (held_we) begin
            held_vld_ff[proc_idx_ff] <= 1'b1;
         end
      end
   end

   // Frame memory with registered read.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         frame_rdata_ff <= frame_mem[ft_addr_in];
      end
      if (frame_we) begin
         frame_mem[ft_addr_ff] <= req_ff.frame_number;
      end
   end

   // Lookup stage results: status, translate flag and the frame product.
   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         status_ff   <= dec.status;
         xlate_ok_ff <= dec.xlate_ok;
         prod_ff     <= PROD_W'(frame_rdata_ff) * PROD_W'(page_size_ff);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.status           <= status_ff;
         rsp_ff.physical_address <= xlate_ok_ff ? addr_sat : '0;
         rsp_ff.free_pages       <= free_count_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Only a successful translation carries an address.
   `PAT_ASSERT_IMPLIES(a_addr_only_on_ok, clock, reset, rsp_valid_ff && (rsp_ff.status != ST_OK), rsp_ff.physical_address == '0)

   // The free-page count only shrinks, except when the budget is rewritten.
   `PAT_ASSERT_NEXT(a_free_never_grows, clock, reset, !(csr_we && (csr_index == CSR_PAGE_BUDGET)), free_count_ff <= $past(free_count_ff))

   // Loading the output register returns the sequencer to accepting requests.
   `PAT_ASSERT_NEXT(a_load_frees_input, clock, reset, rsp_load, rsp_valid_ff && req_ready)

endmodule
